>>> rtl/mpus_pkg.sv
// Types, constants and register codes shared by the modem power-up sequencer.
package mpus_pkg;

  localparam int TICK_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CMP_W     = (TICK_W > CFG_W) ? TICK_W : CFG_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_W-1:0] DISCHARGE_RST   = CFG_W'(3000);
  localparam logic [CFG_W-1:0] PG_TIMEOUT_RST  = CFG_W'(100);
  localparam logic [CFG_W-1:0] SETTLE_RST      = CFG_W'(500);
  localparam logic [CFG_W-1:0] KEY_HOLD_RST    = CFG_W'(1250);
  localparam logic [CFG_W-1:0] ST_TIMEOUT_RST  = CFG_W'(5000);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_DISCHARGE   = 3'd1,
    PH_WAIT_PG     = 3'd2,
    PH_SETTLE      = 3'd3,
    PH_KEY         = 3'd4,
    PH_WAIT_STATUS = 3'd5,
    PH_READY       = 3'd6
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISCHARGE  = 3'd0,
    CFG_PG_TIMEOUT = 3'd1,
    CFG_SETTLE     = 3'd2,
    CFG_KEY_HOLD   = 3'd3,
    CFG_ST_TIMEOUT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] discharge_ms;
    logic [CFG_W-1:0] power_good_timeout_ms;
    logic [CFG_W-1:0] settle_ms;
    logic [CFG_W-1:0] key_hold_ms;
    logic [CFG_W-1:0] status_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   supply_off;
    logic   power_key_level;
    logic   power_good_drive_low;
    logic   uart_enabled;
    logic   link_reset_pulse;
    logic   timeout_fault;
    logic   ready_res;
  } res_t;

endpackage

>>> rtl/mpus_cfg_regs.sv
// Timing register file of the modem power-up sequencer.
module mpus_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mpus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpus_pkg::CFG_W-1:0]     cfg_data,
  output mpus_pkg::cfg_t                 cfg
);
  import mpus_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.discharge_ms          <= DISCHARGE_RST;
      cfg.power_good_timeout_ms <= PG_TIMEOUT_RST;
      cfg.settle_ms             <= SETTLE_RST;
      cfg.key_hold_ms           <= KEY_HOLD_RST;
      cfg.status_timeout_ms     <= ST_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DISCHARGE:  cfg.discharge_ms          <= cfg_data;
        CFG_PG_TIMEOUT: cfg.power_good_timeout_ms <= cfg_data;
        CFG_SETTLE:     cfg.settle_ms             <= cfg_data;
        CFG_KEY_HOLD:   cfg.key_hold_ms           <= cfg_data;
        CFG_ST_TIMEOUT: cfg.status_timeout_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mpus_core.sv
// Phase state machine, tick counter and pin registers of the power-up sequencer.
module mpus_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           action,
  input  logic           power_good_level,
  input  logic           status_level,
  input  mpus_pkg::cfg_t cfg,
  output mpus_pkg::res_t res_next
);
  import mpus_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic [TICK_W-1:0]   elapsed;
  logic [TICK_W-1:0]   elapsed_next;
  logic [TICK_W-1:0]   elapsed_inc;
  logic                supply_off_reg;
  logic                supply_off_next;
  logic                power_key_reg;
  logic                power_key_next;
  logic                drive_low_reg;
  logic                drive_low_next;
  logic                uart_on_reg;
  logic                uart_on_next;
  logic                link_pulse;
  logic                fault;
  logic                discharge_done;
  logic                pg_expired;
  logic                settle_done;
  logic                key_done;
  logic                st_expired;

  // saturating tick count
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + TICK_W'(1);

  assign discharge_done = CMP_W'(elapsed_inc) > CMP_W'(cfg.discharge_ms);
  assign pg_expired     = CMP_W'(elapsed_inc) > CMP_W'(cfg.power_good_timeout_ms);
  assign settle_done    = CMP_W'(elapsed_inc) > CMP_W'(cfg.settle_ms);
  assign key_done       = CMP_W'(elapsed_inc) > CMP_W'(cfg.key_hold_ms);
  assign st_expired     = CMP_W'(elapsed_inc) > CMP_W'(cfg.status_timeout_ms);

  // next phase; a level seen on the pin wins over the timeout
  always_comb begin
    phase_next = phase;
    if (action) begin
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_DISCHARGE: if (discharge_done) phase_next = PH_WAIT_PG;
        PH_WAIT_PG: begin
          if (power_good_level) phase_next = PH_SETTLE;
          else if (pg_expired)  phase_next = PH_IDLE;
        end
        PH_SETTLE:    if (settle_done) phase_next = PH_KEY;
        PH_KEY:       if (key_done) phase_next = PH_WAIT_STATUS;
        PH_WAIT_STATUS: begin
          if (status_level)    phase_next = PH_READY;
          else if (st_expired) phase_next = PH_IDLE;
        end
        PH_READY:     phase_next = PH_READY;
        default:      phase_next = PH_DISCHARGE;
      endcase
    end
  end

  // counter, pins and pulses
  always_comb begin
    elapsed_next    = elapsed;
    supply_off_next = supply_off_reg;
    power_key_next  = power_key_reg;
    drive_low_next  = drive_low_reg;
    uart_on_next    = uart_on_reg;
    link_pulse      = 1'b0;
    fault           = 1'b0;
    if (!action) begin
      elapsed_next = elapsed_inc;
      unique case (phase)
        PH_DISCHARGE: begin
          if (discharge_done) begin
            drive_low_next  = 1'b0;
            supply_off_next = 1'b0;
            elapsed_next    = '0;
          end
        end
        PH_WAIT_PG: begin
          if (power_good_level) begin
            elapsed_next = '0;
            uart_on_next = 1'b1;
          end else if (pg_expired) begin
            fault = 1'b1;
          end
        end
        PH_SETTLE: begin
          if (settle_done) begin
            power_key_next = 1'b0;
            elapsed_next   = '0;
          end
        end
        PH_KEY: begin
          if (key_done) begin
            power_key_next = 1'b1;
            elapsed_next   = '0;
          end
        end
        PH_WAIT_STATUS: begin
          if (status_level) begin
            elapsed_next = '0;
          end else if (st_expired) begin
            fault = 1'b1;
          end
        end
        PH_READY: ;
        default: begin
          supply_off_next = 1'b1;
          drive_low_next  = 1'b1;
          elapsed_next    = '0;
          link_pulse      = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      elapsed        <= '0;
      supply_off_reg <= 1'b1;
      power_key_reg  <= 1'b0;
      drive_low_reg  <= 1'b0;
      uart_on_reg    <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      elapsed        <= elapsed_next;
      supply_off_reg <= supply_off_next;
      power_key_reg  <= power_key_next;
      drive_low_reg  <= drive_low_next;
      uart_on_reg    <= uart_on_next;
    end
  end

  always_comb begin
    res_next.phase                = phase_next;
    res_next.supply_off           = supply_off_next;
    res_next.power_key_level      = power_key_next;
    res_next.power_good_drive_low = drive_low_next;
    res_next.uart_enabled         = uart_on_next;
    res_next.link_reset_pulse     = link_pulse;
    res_next.timeout_fault        = fault;
    res_next.ready_res            = (phase_next == PH_READY);
  end

`ifndef SYNTHESIS
  a_link_enters_discharge: assert property (@(posedge clk) disable iff (rst)
    step && link_pulse |=> phase == PH_DISCHARGE && supply_off_reg && drive_low_reg)
    else $error("link reset without entering discharge");

  a_fault_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && fault |=> phase == PH_IDLE && $stable(supply_off_reg))
    else $error("timeout did not return to idle");

  a_restart_holds_counter: assert property (@(posedge clk) disable iff (rst)
    step && action |=> phase == PH_IDLE && $stable(elapsed) && $stable(uart_on_reg))
    else $error("restart disturbed counter or pins");

  a_uart_sticky: assert property (@(posedge clk) disable iff (rst)
    uart_on_reg |=> uart_on_reg)
    else $error("uart enable dropped");
`endif

endmodule

>>> rtl/modem_power_up_sequencer.sv
// Top level of the modem power-up sequencer: request and result registers.
//
// Requests arrive on the item channel (item_valid / item_stall) and carry
// action (0 = 1 ms tick, 1 = restart) with the sampled power-good and
// status pins. Every request gives exactly one result on the result channel
// (result_valid / result_stall): the phase and pin levels after the step,
// plus link-reset and timeout-fault pulses.
// A request is registered in the request register when it is accepted, and is
// stepped through the phase machine into the result register once that is free,
// which sets result_valid. One request per cycle is sustained while result_stall
// is low; the phase machine and tick counter update together on each step.
// Timing registers are written through cfg_write / cfg_index / cfg_data; the user
// must write them only while no request is in flight, which the block itself does
// not enforce; unknown indexes are ignored. Synchronous reset returns to idle with
// the supply off, clears the counter and result_valid, and loads the default
// timings. While result_stall is high the result holds; one more request is taken
// into the request register, after which item_stall rises until the result is taken.
module modem_power_up_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           action,
  input  logic                           power_good_level,
  input  logic                           status_level,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [2:0]                     phase,
  output logic                           supply_off,
  output logic                           power_key_level,
  output logic                           power_good_drive_low,
  output logic                           uart_enabled,
  output logic                           link_reset_pulse,
  output logic                           timeout_fault,
  output logic                           ready_res,
  input  logic                           cfg_write,
  input  logic [mpus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpus_pkg::CFG_W-1:0]     cfg_data
);
  import mpus_pkg::*;

  cfg_t cfg;
  res_t res_next;
  res_t res;
  logic req_valid;
  logic req_action;
  logic req_pg;
  logic req_st;
  logic res_free;
  logic advance;
  logic accept;

  assign res_free   = !result_valid || !result_stall;
  assign advance    = req_valid && res_free;
  assign item_stall = req_valid && !res_free;
  assign accept     = item_valid && !item_stall;

  mpus_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpus_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .action           (req_action),
    .power_good_level (req_pg),
    .status_level     (req_st),
    .cfg              (cfg),
    .res_next         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_pg     <= power_good_level;
      req_st     <= status_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign phase                = 3'(res.phase);
  assign supply_off           = res.supply_off;
  assign power_key_level      = res.power_key_level;
  assign power_good_drive_low = res.power_good_drive_low;
  assign uart_enabled         = res.uart_enabled;
  assign link_reset_pulse     = res.link_reset_pulse;
  assign timeout_fault        = res.timeout_fault;
  assign ready_res            = res.ready_res;

endmodule
